// File: hdl/ffca_pkg.sv
// Shared types and constants for the first-fit contiguous allocator.
// No dependencies.
package ffca_pkg;

    localparam int unsigned REQ_W           = 11;
    localparam int unsigned START_W         = 10;
    localparam int unsigned NUM_BLOCKS_DFLT = 1024;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_block;
    } t_result;

endpackage

// File: hdl/ffca_req_if.sv
// Request channel: valid/ready handshake carrying the block count.
// Depends on ffca_pkg.
interface ffca_req_if;
    logic                        valid;
    logic                        ready;
    logic [ffca_pkg::REQ_W-1:0]  blocks_requested;

    modport source (output valid, output blocks_requested, input ready);
    modport sink   (input valid, input blocks_requested, output ready);
endinterface

// File: hdl/ffca_rsp_if.sv
// Response channel: valid/ready handshake carrying grant flag and start block.
// Depends on ffca_pkg.
interface ffca_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [ffca_pkg::START_W-1:0]  start_block;

    modport source (output valid, output granted, output start_block, input ready);
    modport sink   (input valid, input granted, input start_block, output ready);
endinterface

// File: hdl/first_fit_contiguous_allocator.sv
// First-fit contiguous block allocator, top level.
// Depends on ffca_pkg, ffca_req_if, ffca_rsp_if, ffca_map_ram, ffca_engine.
//
// i_req carries blocks_requested; each accepted beat yields exactly one beat
// on o_rsp with granted and start_block (start_block is 0 when not granted).
// The map holds one bit per block in a single-port-read, single-port-write RAM.
// A request walks the map from block 0, one block per cycle through the RAM
// read port, and stops at the first free run long enough; the run is then
// written as allocated, one block per cycle through the write port.
// One request is in flight at a time; i_req.ready rises again once the
// result has moved into the output register.
// Reset: the map is cleared by a pass over all NUM_BLOCKS entries, one per
// cycle, during which i_req.ready stays low.
// Receiver stall: the output register holds its beat; the next request can
// still be taken and worked on, and its result waits until the register frees.
module first_fit_contiguous_allocator #(
    parameter int unsigned NUM_BLOCKS = ffca_pkg::NUM_BLOCKS_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ffca_req_if.sink          i_req,
    ffca_rsp_if.source        o_rsp
);

    localparam int unsigned AW = $clog2(NUM_BLOCKS);

    logic              eng_res_valid;
    logic              eng_res_ready;
    ffca_pkg::t_result eng_res;
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic              ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic              ram_rd_data;

    logic              r_out_valid;
    ffca_pkg::t_result r_out;

    ffca_map_ram #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    ffca_engine #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_req.valid),
        .o_req_ready        (i_req.ready),
        .i_blocks_requested (i_req.blocks_requested),
        .o_res_valid        (eng_res_valid),
        .i_res_ready        (eng_res_ready),
        .o_res              (eng_res),
        .o_we               (ram_we),
        .o_wr_addr          (ram_wr_addr),
        .o_wr_data          (ram_wr_data),
        .o_rd_en            (ram_rd_en),
        .o_rd_addr          (ram_rd_addr),
        .i_rd_data          (ram_rd_data)
    );

    assign eng_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (eng_res_valid && eng_res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= eng_res;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted     = r_out.granted;
    assign o_rsp.start_block = r_out.start_block;

endmodule

// File: hdl/ffca_map_ram.sv
// Allocation map: one bit per block, one write and one registered read port.
// Depends on ffca_pkg.
module ffca_map_ram #(
    parameter  int unsigned NUM_BLOCKS = ffca_pkg::NUM_BLOCKS_DFLT,
    localparam int unsigned AW         = $clog2(NUM_BLOCKS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data
);

    logic r_mem [NUM_BLOCKS];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ffca_engine.sv
// Allocation sequencer: clears the map after reset, scans it for the first
// free run, marks the run. Depends on ffca_pkg; drives ffca_map_ram ports.
module ffca_engine #(
    parameter  int unsigned NUM_BLOCKS = ffca_pkg::NUM_BLOCKS_DFLT,
    localparam int unsigned AW         = $clog2(NUM_BLOCKS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [ffca_pkg::REQ_W-1:0]  i_blocks_requested,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output ffca_pkg::t_result           o_res,
    output logic                        o_we,
    output logic [AW-1:0]               o_wr_addr,
    output logic                        o_wr_data,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  logic                        i_rd_data
);

    localparam int unsigned SW = (AW > ffca_pkg::REQ_W) ? AW : ffca_pkg::REQ_W;
    localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REPLY
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_wr_addr;
    logic [AW-1:0]               r_rd_addr;
    logic [AW-1:0]               r_chk_addr;
    logic                        r_issue;
    logic                        r_chk_v;
    logic [ffca_pkg::REQ_W-1:0]  r_want;
    logic [ffca_pkg::REQ_W-1:0]  r_run;
    logic [ffca_pkg::REQ_W-1:0]  r_left;
    ffca_pkg::t_result           r_res;

    logic [ffca_pkg::REQ_W-1:0]  run_nx;
    logic [SW-1:0]               start_sw;
    logic                        hit;

    assign run_nx   = r_run + ffca_pkg::REQ_W'(1);
    assign start_sw = SW'(r_chk_addr) + SW'(1) - SW'(r_want);
    assign hit      = r_chk_v && !i_rd_data && (run_nx == r_want);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_REPLY);
    assign o_res       = r_res;
    assign o_we        = (r_state == S_CLEAR) || (r_state == S_MARK);
    assign o_wr_addr   = r_wr_addr;
    assign o_wr_data   = (r_state == S_MARK);
    assign o_rd_en     = (r_state == S_SCAN) && r_issue;
    assign o_rd_addr   = r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wr_addr <= '0;
            r_issue   <= 1'b0;
            r_chk_v   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                    if (r_wr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_want    <= i_blocks_requested;
                        r_run     <= '0;
                        r_rd_addr <= '0;
                        r_chk_v   <= 1'b0;
                        if (i_blocks_requested == '0) begin
                            r_res   <= '0;
                            r_state <= S_REPLY;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // reads are gated by S_SCAN, so a stale r_issue after a hit is harmless
                    if (r_issue) begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                        if (r_rd_addr == LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_chk_v    <= r_issue;
                    r_chk_addr <= r_rd_addr;
                    if (r_chk_v) begin
                        if (i_rd_data) begin
                            r_run <= '0;
                        end else begin
                            r_run <= run_nx;
                        end
                    end
                    priority if (hit) begin
                        r_wr_addr         <= start_sw[AW-1:0];
                        r_left            <= r_want;
                        r_res.granted     <= 1'b1;
                        r_res.start_block <= start_sw[ffca_pkg::START_W-1:0];
                        r_state           <= S_MARK;
                    end else if (r_chk_v && (r_chk_addr == LAST)) begin
                        r_res   <= '0;
                        r_state <= S_REPLY;
                    end else begin
                    end
                end
                S_MARK: begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                    r_left    <= r_left - ffca_pkg::REQ_W'(1);
                    if (r_left == ffca_pkg::REQ_W'(1)) begin
                        r_state <= S_REPLY;
                    end
                end
                S_REPLY: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for first_fit_contiguous_allocator: directed table,
// then random requests, each checked against a hand-computed row result or an in-bench first-fit map.
// Depends on ffca_pkg, ffca_req_if, ffca_rsp_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned N_BLK       = ffca_pkg::NUM_BLOCKS_DFLT;
    localparam int          N_RANDOM    = 278;
    localparam int          HOLD_CYCLES = 5000;
    localparam int          HOLD_AT     = 30;

    typedef struct {
        logic [ffca_pkg::REQ_W-1:0]   want;
        bit                           known;
        logic                         granted;
        logic [ffca_pkg::START_W-1:0] start;
    } t_row;

    // Map starts empty; rows with known=1 carry a hand-computed result.
    t_row directed_rows [12] = '{
        '{11'd0,    1'b1, 1'b0, 10'd0},
        '{11'd2047, 1'b1, 1'b0, 10'd0},
        '{11'd1025, 1'b1, 1'b0, 10'd0},
        '{11'd1,    1'b1, 1'b1, 10'd0},
        '{11'd1,    1'b1, 1'b1, 10'd1},
        '{11'd2,    1'b1, 1'b1, 10'd2},
        '{11'd1024, 1'b1, 1'b0, 10'd0},
        '{11'd1021, 1'b1, 1'b0, 10'd0},
        '{11'd5,    1'b0, 1'b0, 10'd0},
        '{11'd1023, 1'b1, 1'b0, 10'd0},
        '{11'd16,   1'b0, 1'b0, 10'd0},
        '{11'd0,    1'b1, 1'b0, 10'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffca_req_if req_bus ();
    ffca_rsp_if rsp_bus ();

    first_fit_contiguous_allocator #(
        .NUM_BLOCKS (N_BLK)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    bit                blk_used [N_BLK];
    int                blocks_free = N_BLK;
    ffca_pkg::t_result pending_results [$];
    ffca_pkg::t_result head_result;
    int                errors;
    int                req_beats;
    int                results_seen;
    int                grants_seen;
    int                hold_left;
    bit                hold_done;
    bit                calm;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #60000000;
        $display("TIMEOUT: allocator did not drain");
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // First-fit over the block map; claims the run on success.
    function automatic ffca_pkg::t_result first_fit_alloc(
        input logic [ffca_pkg::REQ_W-1:0] want
    );
        int                run;
        int                base;
        int                b;
        ffca_pkg::t_result res;
        res  = '0;
        run  = 0;
        base = -1;
        if (want != '0) begin
            for (b = 0; b < N_BLK; b++) begin
                if (!blk_used[b]) begin
                    run++;
                    if (run == int'(want)) begin
                        base = b + 1 - int'(want);
                        break;
                    end
                end else begin
                    run = 0;
                end
            end
        end
        if (base >= 0) begin
            for (b = base; b < base + int'(want); b++)
                blk_used[b] = 1'b1;
            blocks_free -= int'(want);
            res.granted     = 1'b1;
            res.start_block = base[ffca_pkg::START_W-1:0];
        end
        return res;
    endfunction

    task automatic send_request(input t_row row);
        ffca_pkg::t_result res;
        while (!calm && $urandom_range(0, 99) < 14) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid            <= 1'b1;
        req_bus.blocks_requested <= row.want;
        do @(posedge i_clk); while (!req_bus.ready);
        req_beats++;
        res = first_fit_alloc(row.want);
        if (row.known) begin
            res.granted     = row.granted;
            res.start_block = row.start;
        end
        pending_results.push_back(res);
    endtask

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!hold_done && req_beats >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: granted=%0b start=%0d",
                                          rsp_bus.granted, rsp_bus.start_block));
            end else begin
                head_result = pending_results.pop_front();
                results_seen++;
                if (rsp_bus.granted === 1'b1)
                    grants_seen++;
                if (rsp_bus.granted !== head_result.granted)
                    report_mismatch($sformatf("result %0d granted: got %b want %b", results_seen,
                                              rsp_bus.granted, head_result.granted));
                if (rsp_bus.start_block !== head_result.start_block)
                    report_mismatch($sformatf("result %0d start_block: got %0d want %0d",
                                              results_seen, rsp_bus.start_block,
                                              head_result.start_block));
            end
        end
    end

    initial begin
        t_row row;
        int   sel;
        i_rst_n                  <= 1'b0;
        req_bus.valid            <= 1'b0;
        req_bus.blocks_requested <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k]);

        for (int i = 0; i < N_RANDOM; i++) begin
            calm      = (i >= 120 && i < 180);
            row.known = 1'b0;
            if (i == N_RANDOM - 2) begin
                row.want = blocks_free[ffca_pkg::REQ_W-1:0];
            end else if (i == N_RANDOM - 1) begin
                row.want = 11'd1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    row.want = ffca_pkg::REQ_W'($urandom_range(1, 4));
                else if (sel < 72)
                    row.want = ffca_pkg::REQ_W'($urandom_range(1, 16));
                else if (sel < 84)
                    row.want = ffca_pkg::REQ_W'($urandom_range(blocks_free + 1, 2047));
                else if (sel < 92)
                    row.want = ffca_pkg::REQ_W'($urandom_range(0, 2047));
                else if (blocks_free > 0 && blocks_free <= 48)
                    row.want = blocks_free[ffca_pkg::REQ_W-1:0];
                else
                    row.want = ffca_pkg::REQ_W'($urandom_range(1, 24));
            end
            send_request(row);
        end
        calm = 1'b0;
        req_bus.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * N_BLK + 16) @(posedge i_clk);

        $display("Ran %0d requests: %0d granted, %0d refused, %0d of %0d blocks still free.",
                 req_beats, grants_seen, results_seen - grants_seen, blocks_free, N_BLK);
        $display("Covered zero and oversize requests, first-fit packing as the map filled,");
        $display("and a %0d-cycle receiver hold-off with the input stalled.", HOLD_CYCLES);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
